/* design/sdspi_pkg.sv */
package sdspi_pkg;

    localparam int BlockBytes = 512;
    localparam int RegisterBytes = 16;

    typedef enum logic [2:0] {
        CMD_INIT = 3'd0,
        CMD_READ = 3'd1,
        CMD_WRITE = 3'd2,
        CMD_REG = 3'd3,
        CMD_BYTE = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_NO_CARD = 3'd1,
        ST_BAD_R1 = 3'd2,
        ST_TOKEN_TO = 3'd3,
        ST_WR_REJECT = 3'd4,
        ST_BUSY_TO = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_MMC = 3'd1,
        KIND_V1 = 3'd2,
        KIND_V2 = 3'd3,
        KIND_V2HC = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        REG_READY_TO = 3'd0,
        REG_TOKEN_TO = 3'd1,
        REG_RESP_POLLS = 3'd2,
        REG_IDLE_RETRIES = 3'd3,
        REG_INIT_RETRIES = 3'd4
    } t_reg_index;

    typedef struct packed {
        logic [2:0] cmd;
        logic [31:0] sector;
        logic [7:0] block_count;
        logic reg_select;
        logic [7:0] rx_byte;
        logic [7:0] write_data;
    } t_in_req;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic tx_valid;
        logic select_active;
        logic fast_clock;
        logic [7:0] read_byte;
        logic read_valid;
        logic wants_data;
        logic done_res;
        logic [2:0] status;
        logic [7:0] card_response;
        logic [2:0] card_kind;
    } t_out_req;

    typedef struct packed {
        logic [23:0] ready_timeout;
        logic [15:0] token_timeout;
        logic [7:0] response_polls;
        logic [7:0] idle_retries;
        logic [15:0] init_retries;
    } t_cfg;

endpackage

/* design/sdspi_cfg_regs.sv */
module sdspi_cfg_regs (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output sdspi_pkg::t_cfg o_cfg
);

    sdspi_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ready_timeout <= 24'hFFFFFF;
            r_cfg.token_timeout <= 16'hFFFF;
            r_cfg.response_polls <= 8'd32;
            r_cfg.idle_retries <= 8'd21;
            r_cfg.init_retries <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sdspi_pkg::REG_READY_TO: r_cfg.ready_timeout <= i_cfg_data;
                sdspi_pkg::REG_TOKEN_TO: r_cfg.token_timeout <= i_cfg_data[15:0];
                sdspi_pkg::REG_RESP_POLLS: r_cfg.response_polls <= i_cfg_data[7:0];
                sdspi_pkg::REG_IDLE_RETRIES: r_cfg.idle_retries <= i_cfg_data[7:0];
                sdspi_pkg::REG_INIT_RETRIES: r_cfg.init_retries <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

endmodule

/* design/sdspi_engine.sv */
module sdspi_engine (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_go,
    input  sdspi_pkg::t_in_req i_req,
    input  sdspi_pkg::t_cfg i_cfg,
    output sdspi_pkg::t_out_req o_res
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_PRE, PH_DESEL, PH_READY, PH_SELFAIL, PH_CMD, PH_RESP, PH_TRAIL,
        PH_TOKEN, PH_DATA, PH_CRC, PH_WREADY, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP,
        PH_STOPTOK
    } t_phase;

    typedef enum logic [2:0] {
        OP_NONE, OP_INIT, OP_READ, OP_WRITE, OP_REG
    } t_op;

    t_phase r_phase, n_phase;
    t_op r_op, n_op;
    logic [2:0] r_card_type, n_card_type, r_kind_wip, n_kind_wip;
    logic [2:0] r_result_code, n_result_code;
    logic r_clock_fast, n_clock_fast;
    logic [31:0] r_address, n_address, r_trailer, n_trailer;
    logic [7:0] r_blocks_left, n_blocks_left, r_last_r1, n_last_r1;
    logic [9:0] r_byte_index, n_byte_index;
    logic [23:0] r_poll_count, n_poll_count;
    logic [15:0] r_attempt, n_attempt;
    logic [5:0] r_cur_cmd, n_cur_cmd;
    sdspi_pkg::t_out_req n_res;

    logic [31:0] w_arg;
    logic [7:0] w_rx, w_n;
    logic [23:0] w_poll_inc;
    logic [15:0] w_att_inc;
    logic [9:0] w_bi_inc, w_len;
    logic [31:0] w_trail_next;

    function automatic logic [7:0] f_cmd_byte(input logic [5:0] cc, input logic [31:0] a,
                                              input logic [9:0] k);
        logic [7:0] v;
        case (k)
            10'd0: v = {2'b01, cc};
            10'd1: v = a[31:24];
            10'd2: v = a[23:16];
            10'd3: v = a[15:8];
            10'd4: v = a[7:0];
            10'd5: v = (cc == 6'd0) ? 8'h95 : ((cc == 6'd8) ? 8'h87 : 8'h01);
            default: v = 8'hFF;
        endcase
        return v;
    endfunction

    always_comb begin
        case (r_cur_cmd)
            6'd8: w_arg = 32'h1AA;
            6'd16: w_arg = 32'(sdspi_pkg::BlockBytes);
            6'd23: w_arg = {24'd0, r_blocks_left};
            6'd17, 6'd18, 6'd24, 6'd25, 6'd41: w_arg = r_address;
            default: w_arg = 32'd0;
        endcase
    end

    assign w_rx = i_req.rx_byte;
    assign w_poll_inc = r_poll_count + 24'd1;
    assign w_att_inc = r_attempt + 16'd1;
    assign w_bi_inc = r_byte_index + 10'd1;
    assign w_len = (r_op == OP_REG) ? 10'(sdspi_pkg::RegisterBytes)
                                    : 10'(sdspi_pkg::BlockBytes);
    assign w_trail_next = {r_trailer[23:0], w_rx};
    assign w_n = (i_req.block_count == 8'd0) ? 8'd1 : i_req.block_count;

    always_comb begin
        logic [2:0] st;
        logic [7:0] r1;
        logic fin, fin_init, cdone, bcmd, rend, bend, spoll;
        logic [5:0] bc;
        logic [2:0] fst;
        t_phase sph;
        logic [2:0] kw;
        n_phase = r_phase; n_op = r_op; n_card_type = r_card_type; n_kind_wip = r_kind_wip;
        n_result_code = r_result_code; n_clock_fast = r_clock_fast; n_address = r_address;
        n_trailer = r_trailer; n_blocks_left = r_blocks_left; n_last_r1 = r_last_r1;
        n_byte_index = r_byte_index; n_poll_count = r_poll_count; n_attempt = r_attempt;
        n_cur_cmd = r_cur_cmd;
        n_res = '0;
        n_res.fast_clock = r_clock_fast;
        st = 3'd0; r1 = 8'd0; fin = 1'b0; fin_init = 1'b0; cdone = 1'b0; bcmd = 1'b0;
        rend = 1'b0; bend = 1'b0; spoll = 1'b0; bc = 6'd0; fst = 3'd0; sph = PH_IDLE;
        kw = r_kind_wip;

        if (i_go) begin
            if (i_req.cmd <= sdspi_pkg::CMD_REG) begin
                if (r_phase == PH_IDLE) begin
                    if (i_req.cmd == sdspi_pkg::CMD_INIT) begin
                        n_op = OP_INIT; n_clock_fast = 1'b0; n_card_type = 3'd0;
                        kw = 3'd0; n_address = '0; n_attempt = '0;
                        n_byte_index = '0;
                        n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                        n_res.fast_clock = 1'b0;
                        n_phase = PH_PRE;
                    end else if (r_card_type == sdspi_pkg::KIND_NONE) begin
                        n_res.done_res = 1'b1; n_res.status = sdspi_pkg::ST_NO_CARD;
                    end else begin
                        n_result_code = 3'd0;
                        if (i_req.cmd == sdspi_pkg::CMD_REG) begin
                            n_op = OP_REG; bcmd = 1'b1;
                            bc = i_req.reg_select ? 6'd9 : 6'd10;
                        end else begin
                            n_blocks_left = w_n;
                            n_address = (r_card_type == sdspi_pkg::KIND_V2HC) ? i_req.sector
                                        : {i_req.sector[22:0], 9'd0};
                            bcmd = 1'b1;
                            if (i_req.cmd == sdspi_pkg::CMD_READ) begin
                                n_op = OP_READ; bc = (w_n == 8'd1) ? 6'd17 : 6'd18;
                            end else begin
                                n_op = OP_WRITE;
                                if (w_n == 8'd1) bc = 6'd24;
                                else if (r_card_type != sdspi_pkg::KIND_MMC) bc = 6'd55;
                                else bc = 6'd25;
                            end
                        end
                    end
                end
            end else if (i_req.cmd == sdspi_pkg::CMD_BYTE && r_phase != PH_IDLE) begin
                case (r_phase)
                    PH_PRE: begin
                        n_byte_index = w_bi_inc;
                        if (w_bi_inc < 10'd10) begin
                            n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                        end else begin
                            bcmd = 1'b1; bc = 6'd0;
                        end
                    end
                    PH_DESEL: begin
                        n_poll_count = '0;
                        n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                        n_res.select_active = 1'b1;
                        n_phase = PH_READY;
                    end
                    PH_READY: begin
                        n_res.tx_valid = 1'b1;
                        if (w_rx == 8'hFF) begin
                            n_byte_index = '0;
                            n_res.tx_byte = f_cmd_byte(r_cur_cmd, w_arg, 10'd0);
                            n_res.select_active = 1'b1;
                            n_phase = PH_CMD;
                        end else begin
                            n_poll_count = w_poll_inc;
                            n_res.tx_byte = 8'hFF;
                            if (w_poll_inc >= i_cfg.ready_timeout) n_phase = PH_SELFAIL;
                            else n_res.select_active = 1'b1;
                        end
                    end
                    PH_SELFAIL: begin
                        n_last_r1 = 8'hFF; cdone = 1'b1; r1 = 8'hFF;
                    end
                    PH_CMD: begin
                        if (r_byte_index >= ((r_cur_cmd == 6'd12) ? 10'd6 : 10'd5)) begin
                            spoll = 1'b1; sph = PH_RESP;
                        end else begin
                            n_byte_index = w_bi_inc;
                            n_res.tx_byte = f_cmd_byte(r_cur_cmd, w_arg, w_bi_inc);
                            n_res.tx_valid = 1'b1; n_res.select_active = 1'b1;
                        end
                    end
                    PH_RESP: begin
                        n_poll_count = w_poll_inc;
                        if (w_rx[7] && w_poll_inc < {16'd0, i_cfg.response_polls}) begin
                            n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                            n_res.select_active = 1'b1;
                        end else begin
                            n_last_r1 = w_rx; cdone = 1'b1; r1 = w_rx;
                        end
                    end
                    PH_TRAIL: begin
                        n_trailer = w_trail_next;
                        n_byte_index = w_bi_inc;
                        if (w_bi_inc < 10'd4) begin
                            n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                            n_res.select_active = 1'b1;
                        end else if (r_cur_cmd == 6'd8) begin
                            if (w_trail_next[15:0] == 16'h01AA) begin
                                n_address = 32'h40000000; n_attempt = '0;
                                bcmd = 1'b1; bc = 6'd55;
                            end else fin_init = 1'b1;
                        end else begin
                            kw = w_trail_next[30] ? sdspi_pkg::KIND_V2HC : sdspi_pkg::KIND_V2;
                            fin_init = 1'b1;
                        end
                    end
                    PH_TOKEN: begin
                        if (w_rx == 8'hFE) begin
                            n_byte_index = '0;
                            n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                            n_res.select_active = 1'b1;
                            n_phase = PH_DATA;
                        end else begin
                            n_poll_count = w_poll_inc;
                            if (w_poll_inc >= {8'd0, i_cfg.token_timeout}) begin
                                rend = 1'b1; st = sdspi_pkg::ST_TOKEN_TO;
                            end else begin
                                n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                                n_res.select_active = 1'b1;
                            end
                        end
                    end
                    PH_DATA: begin
                        n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                        n_res.select_active = 1'b1;
                        n_res.read_byte = w_rx; n_res.read_valid = 1'b1;
                        if (w_bi_inc < w_len) n_byte_index = w_bi_inc;
                        else begin
                            n_byte_index = '0; n_phase = PH_CRC;
                        end
                    end
                    PH_CRC: begin
                        n_byte_index = w_bi_inc;
                        if (w_bi_inc < 10'd2) begin
                            n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                            n_res.select_active = 1'b1;
                        end else begin
                            rend = 1'b1; st = sdspi_pkg::ST_OK;
                        end
                    end
                    PH_WREADY: begin
                        if (w_rx == 8'hFF) begin
                            n_res.tx_valid = 1'b1; n_res.select_active = 1'b1;
                            if (r_cur_cmd == 6'd25 && r_blocks_left == 8'd0) begin
                                n_res.tx_byte = 8'hFD; n_phase = PH_STOPTOK;
                            end else begin
                                n_res.tx_byte = (r_cur_cmd == 6'd25) ? 8'hFC : 8'hFE;
                                n_res.wants_data = 1'b1; n_phase = PH_WTOKEN;
                            end
                        end else begin
                            n_poll_count = w_poll_inc;
                            if (w_poll_inc >= i_cfg.ready_timeout) begin
                                bend = 1'b1; st = sdspi_pkg::ST_BUSY_TO;
                            end else begin
                                n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                                n_res.select_active = 1'b1;
                            end
                        end
                    end
                    PH_WTOKEN: begin
                        n_byte_index = '0;
                        n_res.tx_byte = i_req.write_data; n_res.tx_valid = 1'b1;
                        n_res.select_active = 1'b1; n_res.wants_data = 1'b1;
                        n_phase = PH_WDATA;
                    end
                    PH_WDATA: begin
                        n_res.tx_valid = 1'b1; n_res.select_active = 1'b1;
                        if (w_bi_inc < 10'(sdspi_pkg::BlockBytes)) begin
                            n_byte_index = w_bi_inc;
                            n_res.tx_byte = i_req.write_data;
                            n_res.wants_data = (11'(w_bi_inc) + 11'd1
                                                < 11'(sdspi_pkg::BlockBytes));
                        end else begin
                            n_byte_index = '0; n_res.tx_byte = 8'hFF; n_phase = PH_WCRC;
                        end
                    end
                    PH_WCRC: begin
                        n_byte_index = w_bi_inc;
                        n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1;
                        n_res.select_active = 1'b1;
                        if (w_bi_inc >= 10'd2) n_phase = PH_WRESP;
                    end
                    PH_WRESP: begin
                        bend = 1'b1;
                        st = (w_rx[4:0] != 5'h05) ? sdspi_pkg::ST_WR_REJECT : sdspi_pkg::ST_OK;
                    end
                    PH_STOPTOK: begin
                        fin = 1'b1; fst = r_result_code;
                    end
                    default: begin
                        n_phase = PH_IDLE; n_op = OP_NONE;
                    end
                endcase
            end
        end

        // Command completion.
        if (cdone) begin
            if (r_op == OP_INIT) begin
                case (r_cur_cmd)
                    6'd0: begin
                        if (r1 == 8'h01) begin
                            bcmd = 1'b1; bc = 6'd8;
                        end else begin
                            n_attempt = w_att_inc;
                            if (w_att_inc < {8'd0, i_cfg.idle_retries}) begin
                                bcmd = 1'b1; bc = 6'd0;
                            end else fin_init = 1'b1;
                        end
                    end
                    6'd8: begin
                        if (r1 == 8'h01) begin
                            n_trailer = '0; spoll = 1'b1; sph = PH_TRAIL;
                        end else begin
                            n_address = '0; kw = 3'd0; n_attempt = '0;
                            bcmd = 1'b1; bc = 6'd55;
                        end
                    end
                    6'd55: begin
                        bcmd = 1'b1; bc = 6'd41;
                    end
                    6'd41: begin
                        if (r_address != 32'd0 && r1 == 8'd0) begin
                            bcmd = 1'b1; bc = 6'd58;
                        end else if (r_address == 32'd0 && r_kind_wip == 3'd0) begin
                            n_attempt = '0; bcmd = 1'b1;
                            if (r1 <= 8'd1) begin
                                kw = sdspi_pkg::KIND_V1; bc = 6'd55;
                            end else begin
                                kw = sdspi_pkg::KIND_MMC; bc = 6'd1;
                            end
                        end else if (r_address == 32'd0 && r1 == 8'd0) begin
                            bcmd = 1'b1; bc = 6'd16;
                        end else begin
                            n_attempt = w_att_inc;
                            if (w_att_inc < i_cfg.init_retries) begin
                                bcmd = 1'b1; bc = 6'd55;
                            end else begin
                                kw = 3'd0; fin_init = 1'b1;
                            end
                        end
                    end
                    6'd1: begin
                        if (r1 == 8'd0) begin
                            bcmd = 1'b1; bc = 6'd16;
                        end else begin
                            n_attempt = w_att_inc;
                            if (w_att_inc < i_cfg.init_retries) begin
                                bcmd = 1'b1; bc = 6'd1;
                            end else begin
                                kw = 3'd0; fin_init = 1'b1;
                            end
                        end
                    end
                    6'd58: begin
                        if (r1 == 8'd0) begin
                            n_trailer = '0; spoll = 1'b1; sph = PH_TRAIL;
                        end else begin
                            kw = 3'd0; fin_init = 1'b1;
                        end
                    end
                    default: begin
                        if (r1 != 8'd0) kw = 3'd0;
                        fin_init = 1'b1;
                    end
                endcase
            end else begin
                case (r_cur_cmd)
                    6'd12: begin
                        fin = 1'b1; fst = r_result_code;
                    end
                    6'd55: begin
                        bcmd = 1'b1; bc = 6'd23;
                    end
                    6'd23: begin
                        bcmd = 1'b1; bc = 6'd25;
                    end
                    6'd24, 6'd25: begin
                        if (r1 != 8'd0) begin
                            fin = 1'b1; fst = sdspi_pkg::ST_BAD_R1;
                        end else begin
                            spoll = 1'b1; sph = PH_WREADY;
                        end
                    end
                    default: begin
                        if (r1 != 8'd0) begin
                            fin = 1'b1; fst = sdspi_pkg::ST_BAD_R1;
                        end else begin
                            spoll = 1'b1; sph = PH_TOKEN;
                        end
                    end
                endcase
            end
        end

        if (rend) begin
            if (r_op == OP_READ && r_cur_cmd == 6'd18 && st == 3'd0
                && r_blocks_left != 8'd1) begin
                n_blocks_left = r_blocks_left - 8'd1;
                spoll = 1'b1; sph = PH_TOKEN;
            end else if (r_op == OP_READ && r_cur_cmd == 6'd18) begin
                if (st == 3'd0) n_blocks_left = r_blocks_left - 8'd1;
                n_result_code = st; bcmd = 1'b1; bc = 6'd12;
            end else begin
                fin = 1'b1; fst = st;
            end
        end

        if (bend) begin
            if (r_cur_cmd != 6'd25) begin
                fin = 1'b1; fst = st;
            end else if (r_blocks_left == 8'd0) begin
                fin = 1'b1; fst = (r_result_code != 3'd0) ? r_result_code : st;
            end else begin
                if (st == 3'd0) n_blocks_left = r_blocks_left - 8'd1;
                else begin
                    n_result_code = st; n_blocks_left = 8'd0;
                end
                spoll = 1'b1; sph = PH_WREADY;
            end
        end

        n_kind_wip = kw;

        if (bcmd) begin
            n_cur_cmd = bc;
            n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1; n_res.select_active = 1'b0;
            n_phase = PH_DESEL;
        end
        if (spoll) begin
            n_poll_count = '0; n_byte_index = '0;
            n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1; n_res.select_active = 1'b1;
            n_phase = sph;
        end
        if (fin_init) begin
            n_card_type = kw;
            fin = 1'b1;
            fst = (kw != 3'd0) ? sdspi_pkg::ST_OK : sdspi_pkg::ST_NO_CARD;
        end
        if (fin) begin
            n_res.tx_byte = 8'hFF; n_res.tx_valid = 1'b1; n_res.select_active = 1'b0;
            n_res.done_res = 1'b1; n_res.status = fst;
            n_phase = PH_IDLE; n_op = OP_NONE;
        end
        if (fin_init) n_clock_fast = 1'b1;

        n_res.card_response = n_last_r1;
        n_res.card_kind = n_card_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE; r_op <= OP_NONE; r_card_type <= '0; r_kind_wip <= '0;
            r_result_code <= '0; r_clock_fast <= 1'b0; r_address <= '0; r_trailer <= '0;
            r_blocks_left <= '0; r_last_r1 <= 8'hFF; r_byte_index <= '0;
            r_poll_count <= '0; r_attempt <= '0; r_cur_cmd <= '0;
        end else if (i_go) begin
            r_phase <= n_phase; r_op <= n_op; r_card_type <= n_card_type;
            r_kind_wip <= n_kind_wip; r_result_code <= n_result_code;
            r_clock_fast <= n_clock_fast; r_address <= n_address; r_trailer <= n_trailer;
            r_blocks_left <= n_blocks_left; r_last_r1 <= n_last_r1;
            r_byte_index <= n_byte_index; r_poll_count <= n_poll_count;
            r_attempt <= n_attempt; r_cur_cmd <= n_cur_cmd;
        end
    end

    assign o_res = n_res;

`ifndef NO_ASSERTIONS
    a_idle_no_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_op == OP_NONE))
        else $error("idle phase with an operation pending");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && n_res.done_res) |=> (r_phase == PH_IDLE))
        else $error("done without returning to idle");
    a_read_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && n_res.read_valid) |-> n_res.select_active)
        else $error("read byte while deselected");
    a_fast_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && n_res.done_res && r_op == OP_INIT) |=> r_clock_fast)
        else $error("init finished on slow clock");
`endif

endmodule

/* design/sd_spi_host_engine_core.sv */
// Channel   Direction  Handshake              Payload
// input     in         i_in_valid/o_in_stall  sdspi_pkg::t_in_req
// output    out        o_out_valid/i_out_stall sdspi_pkg::t_out_req
// config    in         i_cfg_valid/o_cfg_ready index 3 bits, data 24 bits
// Each result is formed combinationally and registered; one request per cycle unless stalled.
// A skid register lets a request be taken while the previous result waits.
// Reset is synchronous and active low; configuration is ready at once.
// The input is stalled only while both the output and skid registers are full.
module sd_spi_host_engine_core (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  sdspi_pkg::t_in_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output sdspi_pkg::t_out_req o_out_data,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    sdspi_pkg::t_cfg w_cfg;
    sdspi_pkg::t_out_req w_res, r_out, r_skid;
    logic r_out_v, r_skid_v, w_go, w_pop;

    sdspi_cfg_regs u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_cfg(w_cfg)
    );

    assign o_in_stall = r_skid_v;
    assign w_go = i_in_valid && !r_skid_v;
    assign w_pop = r_out_v && !i_out_stall;

    sdspi_engine u_eng (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_go), .i_req(i_in_data),
        .i_cfg(w_cfg), .o_res(w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0; r_skid_v <= 1'b0;
        end else begin
            if (r_skid_v) begin
                if (w_pop) begin
                    r_out <= r_skid; r_skid_v <= 1'b0;
                end
            end else if (w_go) begin
                if (!r_out_v || w_pop) begin
                    r_out <= w_res; r_out_v <= 1'b1;
                end else begin
                    r_skid <= w_res; r_skid_v <= 1'b1;
                end
            end else if (w_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data = r_out;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid full while output empty");
    a_no_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !w_pop) |=> r_skid_v)
        else $error("skid lost a result");
    a_go_when_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go |=> r_out_v)
        else $error("accepted request produced no result");
`endif

endmodule

/* dv/sd_spi_host_engine_core_tb.sv */
module sd_spi_host_engine_core_tb;

    typedef enum int {
        PH_IDLE, PH_PRE, PH_DESEL, PH_READY, PH_SELFAIL, PH_CMD, PH_RESP, PH_TRAIL,
        PH_TOKEN, PH_DATA, PH_CRC, PH_WREADY, PH_WTOKEN, PH_WDATA, PH_WCRC, PH_WRESP,
        PH_STOPTOK
    } t_phase;

    typedef enum int {OP_NONE, OP_INIT, OP_READ, OP_WRITE, OP_REG} t_op;

    localparam logic [5:0] C_GO_IDLE = 6'd0;
    localparam logic [5:0] C_MMC_OP = 6'd1;
    localparam logic [5:0] C_SEND_IF = 6'd8;
    localparam logic [5:0] C_SEND_CSD = 6'd9;
    localparam logic [5:0] C_SEND_CID = 6'd10;
    localparam logic [5:0] C_STOP = 6'd12;
    localparam logic [5:0] C_SET_BLEN = 6'd16;
    localparam logic [5:0] C_READ_ONE = 6'd17;
    localparam logic [5:0] C_READ_MANY = 6'd18;
    localparam logic [5:0] C_SET_COUNT = 6'd23;
    localparam logic [5:0] C_WRITE_ONE = 6'd24;
    localparam logic [5:0] C_WRITE_MANY = 6'd25;
    localparam logic [5:0] C_APP_OP = 6'd41;
    localparam logic [5:0] C_APP = 6'd55;
    localparam logic [5:0] C_READ_OCR = 6'd58;

    localparam int ITEM_TARGET = 1650;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        sdspi_pkg::t_in_req req;
        sdspi_pkg::t_out_req res;
    } t_pending;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    sdspi_pkg::t_in_req i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    sdspi_pkg::t_out_req o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [23:0] i_cfg_data;

    sd_spi_host_engine_core uut (.*);

    // Engine state mirrored by the predictor.
    logic [23:0] cfg_ready_to;
    logic [15:0] cfg_token_to;
    logic [7:0] cfg_resp_polls;
    logic [7:0] cfg_idle_retries;
    logic [15:0] cfg_init_retries;
    t_phase eng_phase;
    t_op eng_op;
    logic [2:0] card_type;
    logic [2:0] kind_wip;
    logic [2:0] result_code;
    logic clk_fast;
    logic [31:0] address;
    logic [7:0] blocks_left;
    logic [9:0] byte_index;
    logic [23:0] poll_count;
    logic [15:0] attempt_count;
    logic [5:0] cur_cmd;
    logic [7:0] last_r1;
    logic [31:0] trailer;
    sdspi_pkg::t_out_req res;

    t_pending pending_q[$];
    sdspi_pkg::t_out_req expected_q[$];
    sdspi_pkg::t_out_req driven_res;
    bit in_taken;
    int errors;
    int cycle_count;
    int quiet_cycles;

    task automatic emit(input logic [7:0] b, input logic cs);
        res.tx_byte = b;
        res.tx_valid = 1'b1;
        res.select_active = cs;
        res.fast_clock = clk_fast;
    endtask

    function automatic logic [31:0] cmd_arg();
        case (cur_cmd)
            C_SEND_IF: return 32'h1AA;
            C_SET_BLEN: return sdspi_pkg::BlockBytes;
            C_SET_COUNT: return {24'd0, blocks_left};
            C_READ_ONE, C_READ_MANY, C_WRITE_ONE, C_WRITE_MANY, C_APP_OP: return address;
            default: return 32'd0;
        endcase
    endfunction

    function automatic logic [7:0] cmd_byte(input int k);
        logic [31:0] a;
        a = cmd_arg();
        case (k)
            0: return 8'h40 | {2'b00, cur_cmd};
            1: return a[31:24];
            2: return a[23:16];
            3: return a[15:8];
            4: return a[7:0];
            5: return cur_cmd == C_GO_IDLE ? 8'h95 : (cur_cmd == C_SEND_IF ? 8'h87 : 8'h01);
            default: return 8'hFF;
        endcase
    endfunction

    task automatic begin_cmd(input logic [5:0] c);
        cur_cmd = c;
        emit(8'hFF, 1'b0);
        eng_phase = PH_DESEL;
    endtask

    task automatic start_poll(input t_phase p);
        poll_count = '0;
        byte_index = '0;
        emit(8'hFF, 1'b1);
        eng_phase = p;
    endtask

    task automatic finish_op(input logic [2:0] st);
        emit(8'hFF, 1'b0);
        res.done_res = 1'b1;
        res.status = st;
        eng_phase = PH_IDLE;
        eng_op = OP_NONE;
    endtask

    task automatic finish_init();
        card_type = kind_wip;
        finish_op(kind_wip != sdspi_pkg::KIND_NONE ? sdspi_pkg::ST_OK : sdspi_pkg::ST_NO_CARD);
        clk_fast = 1'b1;
    endtask

    task automatic init_cmd_done(input logic [7:0] r1);
        case (cur_cmd)
            C_GO_IDLE: begin
                if (r1 == 8'h01) begin
                    begin_cmd(C_SEND_IF);
                end else begin
                    attempt_count++;
                    if (attempt_count < cfg_idle_retries) begin_cmd(C_GO_IDLE);
                    else finish_init();
                end
            end
            C_SEND_IF: begin
                if (r1 == 8'h01) begin
                    trailer = '0;
                    start_poll(PH_TRAIL);
                end else begin
                    address = '0;
                    kind_wip = sdspi_pkg::KIND_NONE;
                    attempt_count = '0;
                    begin_cmd(C_APP);
                end
            end
            C_APP: begin_cmd(C_APP_OP);
            C_APP_OP: begin
                if (address != 0 && r1 == 0) begin
                    begin_cmd(C_READ_OCR);
                end else if (address == 0 && kind_wip == sdspi_pkg::KIND_NONE) begin
                    attempt_count = '0;
                    if (r1 <= 1) begin
                        kind_wip = sdspi_pkg::KIND_V1;
                        begin_cmd(C_APP);
                    end else begin
                        kind_wip = sdspi_pkg::KIND_MMC;
                        begin_cmd(C_MMC_OP);
                    end
                end else if (address == 0 && r1 == 0) begin
                    begin_cmd(C_SET_BLEN);
                end else begin
                    attempt_count++;
                    if (attempt_count < cfg_init_retries) begin
                        begin_cmd(C_APP);
                    end else begin
                        kind_wip = sdspi_pkg::KIND_NONE;
                        finish_init();
                    end
                end
            end
            C_MMC_OP: begin
                if (r1 == 0) begin
                    begin_cmd(C_SET_BLEN);
                end else begin
                    attempt_count++;
                    if (attempt_count < cfg_init_retries) begin
                        begin_cmd(C_MMC_OP);
                    end else begin
                        kind_wip = sdspi_pkg::KIND_NONE;
                        finish_init();
                    end
                end
            end
            C_READ_OCR: begin
                if (r1 == 0) begin
                    trailer = '0;
                    start_poll(PH_TRAIL);
                end else begin
                    kind_wip = sdspi_pkg::KIND_NONE;
                    finish_init();
                end
            end
            default: begin
                if (r1 != 0) kind_wip = sdspi_pkg::KIND_NONE;
                finish_init();
            end
        endcase
    endtask

    task automatic cmd_done(input logic [7:0] r1);
        if (eng_op == OP_INIT) begin
            init_cmd_done(r1);
        end else begin
            case (cur_cmd)
                C_STOP: finish_op(result_code);
                C_APP: begin_cmd(C_SET_COUNT);
                C_SET_COUNT: begin_cmd(C_WRITE_MANY);
                C_WRITE_ONE, C_WRITE_MANY: begin
                    if (r1 != 0) finish_op(sdspi_pkg::ST_BAD_R1);
                    else start_poll(PH_WREADY);
                end
                default: begin
                    if (r1 != 0) finish_op(sdspi_pkg::ST_BAD_R1);
                    else start_poll(PH_TOKEN);
                end
            endcase
        end
    endtask

    task automatic recv_end(input logic [2:0] st);
        if (eng_op == OP_READ && cur_cmd == C_READ_MANY) begin
            if (st == sdspi_pkg::ST_OK) begin
                blocks_left--;
            end
            if (st == sdspi_pkg::ST_OK && blocks_left != 0) begin
                start_poll(PH_TOKEN);
            end else begin
                result_code = st;
                begin_cmd(C_STOP);
            end
        end else begin
            finish_op(st);
        end
    endtask

    task automatic block_end(input logic [2:0] st);
        if (cur_cmd != C_WRITE_MANY) begin
            finish_op(st);
        end else if (blocks_left == 0) begin
            finish_op(result_code != sdspi_pkg::ST_OK ? result_code : st);
        end else begin
            if (st == sdspi_pkg::ST_OK) begin
                blocks_left--;
            end else begin
                result_code = st;
                blocks_left = '0;
            end
            start_poll(PH_WREADY);
        end
    endtask

    task automatic on_byte(input logic [7:0] rx, input logic [7:0] wd);
        int len;
        len = (eng_op == OP_REG) ? sdspi_pkg::RegisterBytes : sdspi_pkg::BlockBytes;
        case (eng_phase)
            PH_PRE: begin
                byte_index++;
                if (byte_index < 10) emit(8'hFF, 1'b0);
                else begin_cmd(C_GO_IDLE);
            end
            PH_DESEL: begin
                poll_count = '0;
                emit(8'hFF, 1'b1);
                eng_phase = PH_READY;
            end
            PH_READY: begin
                if (rx == 8'hFF) begin
                    byte_index = '0;
                    emit(cmd_byte(0), 1'b1);
                    eng_phase = PH_CMD;
                end else begin
                    poll_count++;
                    if (poll_count >= cfg_ready_to) begin
                        emit(8'hFF, 1'b0);
                        eng_phase = PH_SELFAIL;
                    end else begin
                        emit(8'hFF, 1'b1);
                    end
                end
            end
            PH_SELFAIL: begin
                last_r1 = 8'hFF;
                cmd_done(8'hFF);
            end
            PH_CMD: begin
                if (byte_index >= (cur_cmd == C_STOP ? 6 : 5)) begin
                    start_poll(PH_RESP);
                end else begin
                    byte_index++;
                    emit(cmd_byte(byte_index), 1'b1);
                end
            end
            PH_RESP: begin
                poll_count++;
                if (rx[7] && poll_count < cfg_resp_polls) begin
                    emit(8'hFF, 1'b1);
                end else begin
                    last_r1 = rx;
                    cmd_done(rx);
                end
            end
            PH_TRAIL: begin
                trailer = {trailer[23:0], rx};
                byte_index++;
                if (byte_index < 4) begin
                    emit(8'hFF, 1'b1);
                end else if (cur_cmd == C_SEND_IF) begin
                    if (trailer[15:0] == 16'h01AA) begin
                        address = 32'h4000_0000;
                        attempt_count = '0;
                        begin_cmd(C_APP);
                    end else begin
                        finish_init();
                    end
                end else begin
                    kind_wip = trailer[30] ? sdspi_pkg::KIND_V2HC : sdspi_pkg::KIND_V2;
                    finish_init();
                end
            end
            PH_TOKEN: begin
                if (rx == 8'hFE) begin
                    byte_index = '0;
                    emit(8'hFF, 1'b1);
                    eng_phase = PH_DATA;
                end else begin
                    poll_count++;
                    if (poll_count >= cfg_token_to) recv_end(sdspi_pkg::ST_TOKEN_TO);
                    else emit(8'hFF, 1'b1);
                end
            end
            PH_DATA: begin
                byte_index++;
                if (byte_index >= len) begin
                    byte_index = '0;
                    eng_phase = PH_CRC;
                end
                emit(8'hFF, 1'b1);
                res.read_byte = rx;
                res.read_valid = 1'b1;
            end
            PH_CRC: begin
                byte_index++;
                if (byte_index < 2) emit(8'hFF, 1'b1);
                else recv_end(sdspi_pkg::ST_OK);
            end
            PH_WREADY: begin
                if (rx == 8'hFF) begin
                    if (cur_cmd == C_WRITE_MANY && blocks_left == 0) begin
                        emit(8'hFD, 1'b1);
                        eng_phase = PH_STOPTOK;
                    end else begin
                        emit(cur_cmd == C_WRITE_MANY ? 8'hFC : 8'hFE, 1'b1);
                        res.wants_data = 1'b1;
                        eng_phase = PH_WTOKEN;
                    end
                end else begin
                    poll_count++;
                    if (poll_count >= cfg_ready_to) block_end(sdspi_pkg::ST_BUSY_TO);
                    else emit(8'hFF, 1'b1);
                end
            end
            PH_WTOKEN: begin
                byte_index = '0;
                emit(wd, 1'b1);
                res.wants_data = 1'b1;
                eng_phase = PH_WDATA;
            end
            PH_WDATA: begin
                byte_index++;
                if (byte_index < sdspi_pkg::BlockBytes) begin
                    emit(wd, 1'b1);
                    res.wants_data = (byte_index + 1 < sdspi_pkg::BlockBytes);
                end else begin
                    byte_index = '0;
                    emit(8'hFF, 1'b1);
                    eng_phase = PH_WCRC;
                end
            end
            PH_WCRC: begin
                byte_index++;
                emit(8'hFF, 1'b1);
                if (byte_index >= 2) eng_phase = PH_WRESP;
            end
            PH_WRESP: block_end(rx[4:0] != 5'h05 ? sdspi_pkg::ST_WR_REJECT : sdspi_pkg::ST_OK);
            PH_STOPTOK: finish_op(result_code);
            default: begin
                eng_phase = PH_IDLE;
                eng_op = OP_NONE;
            end
        endcase
    endtask

    task automatic start_op(input sdspi_pkg::t_in_req it);
        logic [7:0] n;
        if (it.cmd == sdspi_pkg::CMD_INIT) begin
            eng_op = OP_INIT;
            clk_fast = 1'b0;
            card_type = sdspi_pkg::KIND_NONE;
            kind_wip = sdspi_pkg::KIND_NONE;
            address = '0;
            attempt_count = '0;
            byte_index = '0;
            emit(8'hFF, 1'b0);
            eng_phase = PH_PRE;
        end else if (card_type == sdspi_pkg::KIND_NONE) begin
            res.done_res = 1'b1;
            res.status = sdspi_pkg::ST_NO_CARD;
        end else begin
            result_code = sdspi_pkg::ST_OK;
            if (it.cmd == sdspi_pkg::CMD_REG) begin
                eng_op = OP_REG;
                begin_cmd(it.reg_select ? C_SEND_CSD : C_SEND_CID);
            end else begin
                n = (it.block_count == 0) ? 8'd1 : it.block_count;
                blocks_left = n;
                address = (card_type == sdspi_pkg::KIND_V2HC) ? it.sector
                                                              : {it.sector[22:0], 9'd0};
                if (it.cmd == sdspi_pkg::CMD_READ) begin
                    eng_op = OP_READ;
                    begin_cmd(n == 1 ? C_READ_ONE : C_READ_MANY);
                end else begin
                    eng_op = OP_WRITE;
                    if (n == 1) begin_cmd(C_WRITE_ONE);
                    else if (card_type != sdspi_pkg::KIND_MMC) begin_cmd(C_APP);
                    else begin_cmd(C_WRITE_MANY);
                end
            end
        end
    endtask

    task automatic predict_exchange(input sdspi_pkg::t_in_req it,
                                    output sdspi_pkg::t_out_req o);
        res = '0;
        res.fast_clock = clk_fast;
        if (it.cmd <= sdspi_pkg::CMD_REG) begin
            if (eng_phase == PH_IDLE) start_op(it);
        end else if (it.cmd == sdspi_pkg::CMD_BYTE && eng_phase != PH_IDLE) begin
            on_byte(it.rx_byte, it.write_data);
        end
        res.card_response = last_r1;
        res.card_kind = card_type;
        o = res;
    endtask

    // Card answer for the byte exchange in progress, mostly well formed.
    function automatic logic [7:0] card_answer();
        logic [7:0] r;
        r = 8'($urandom);
        if ($urandom_range(99) < 8) return r;
        case (eng_phase)
            PH_READY: return 8'hFF;
            PH_RESP: begin
                if ($urandom_range(99) < 20) return 8'hFF;
                case (cur_cmd)
                    C_GO_IDLE, C_APP: return 8'h01;
                    C_SEND_IF: return ($urandom_range(99) < 25) ? 8'h05 : 8'h01;
                    C_APP_OP: begin
                        if (address == 0 && kind_wip == sdspi_pkg::KIND_NONE) begin
                            case ($urandom_range(2))
                                0: return 8'h00;
                                1: return 8'h01;
                                default: return 8'h05;
                            endcase
                        end
                        return ($urandom_range(99) < 30) ? 8'h01 : 8'h00;
                    end
                    C_STOP: return r;
                    default: return ($urandom_range(99) < 5) ? 8'h04 : 8'h00;
                endcase
            end
            PH_TRAIL: begin
                if (cur_cmd == C_READ_OCR) return (byte_index == 0) ? (r | 8'h80) : r;
                case (byte_index)
                    0, 1: return 8'h00;
                    2: return 8'h01;
                    default: return 8'hAA;
                endcase
            end
            PH_TOKEN: return ($urandom_range(99) < 70) ? 8'hFE : 8'hFF;
            PH_WREADY: return ($urandom_range(99) < 85) ? 8'hFF : 8'h00;
            PH_WRESP: return (r & 8'hE0) | 8'h05;
            default: return r;
        endcase
    endfunction

    task automatic queue_request(input sdspi_pkg::t_in_req it);
        t_pending p;
        p.req = it;
        predict_exchange(it, p.res);
        pending_q.push_back(p);
    endtask

    function automatic sdspi_pkg::t_in_req random_req(input logic [2:0] c);
        sdspi_pkg::t_in_req it;
        it.cmd = c;
        it.sector = $urandom;
        it.block_count = 8'($urandom);
        it.reg_select = 1'($urandom);
        it.rx_byte = 8'($urandom);
        it.write_data = 8'($urandom);
        return it;
    endfunction

    task automatic write_reg(input sdspi_pkg::t_reg_index idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic load_settings(input int sel);
        logic [23:0] v [5];
        case (sel % 4)
            0: v = '{24'hFFFFFF, 24'hFFFF, 24'hFF, 24'hFF, 24'hFFFF};
            1: v = '{24'd1, 24'd1, 24'd1, 24'd1, 24'd1};
            2: v = '{24'($urandom_range(1, 8)), 24'($urandom_range(1, 6)),
                     24'($urandom_range(2, 40)), 24'($urandom_range(1, 30)),
                     24'($urandom_range(1, 50))};
            default: v = '{24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom_range(1, 16'hFFFF)),
                           24'($urandom_range(1, 255)), 24'($urandom_range(1, 255)),
                           24'($urandom_range(1, 16'hFFFF))};
        endcase
        wait (pending_q.size() == 0 && expected_q.size() == 0 && !i_in_valid);
        write_reg(sdspi_pkg::REG_READY_TO, v[0]);
        write_reg(sdspi_pkg::REG_TOKEN_TO, v[1]);
        write_reg(sdspi_pkg::REG_RESP_POLLS, v[2]);
        write_reg(sdspi_pkg::REG_IDLE_RETRIES, v[3]);
        write_reg(sdspi_pkg::REG_INIT_RETRIES, v[4]);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_ready_to = v[0];
        cfg_token_to = v[1][15:0];
        cfg_resp_polls = v[2][7:0];
        cfg_idle_retries = v[3][7:0];
        cfg_init_retries = v[4][15:0];
    endtask

    task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
        errors++;
        $display("mismatch in %s: expected %0h, got %0h", field, want, got);
    endtask

    task automatic check_result(input sdspi_pkg::t_out_req want,
                                input sdspi_pkg::t_out_req got);
        if (got.tx_byte !== want.tx_byte) report("tx_byte", want.tx_byte, got.tx_byte);
        if (got.tx_valid !== want.tx_valid) report("tx_valid", want.tx_valid, got.tx_valid);
        if (got.select_active !== want.select_active)
            report("select_active", want.select_active, got.select_active);
        if (got.fast_clock !== want.fast_clock)
            report("fast_clock", want.fast_clock, got.fast_clock);
        if (got.read_byte !== want.read_byte) report("read_byte", want.read_byte, got.read_byte);
        if (got.read_valid !== want.read_valid)
            report("read_valid", want.read_valid, got.read_valid);
        if (got.wants_data !== want.wants_data)
            report("wants_data", want.wants_data, got.wants_data);
        if (got.done_res !== want.done_res) report("done_res", want.done_res, got.done_res);
        if (got.status !== want.status) report("status", want.status, got.status);
        if (got.card_response !== want.card_response)
            report("card_response", want.card_response, got.card_response);
        if (got.card_kind !== want.card_kind) report("card_kind", want.card_kind, got.card_kind);
    endtask

    function automatic bit idle_now();
        if (cycle_count > 600 && cycle_count < 1300) return 1'b0;
        return $urandom_range(99) < 6;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        t_pending p;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (in_taken || !i_in_valid) begin
            if (pending_q.size() != 0 && !idle_now()) begin
                p = pending_q.pop_front();
                driven_res = p.res;
                i_in_data <= p.req;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= i_rst_n && idle_now();
    end

    always @(posedge i_clk) begin
        sdspi_pkg::t_out_req want;
        cycle_count++;
        in_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (in_taken) expected_q.push_back(driven_res);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                report("result count", 8'd0, 8'd1);
            end else begin
                want = expected_q.pop_front();
                check_result(want, o_out_data);
            end
        end
        if (in_taken || (i_rst_n && o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        sdspi_pkg::t_in_req it;
        int issued;
        int op_count;
        int sel;
        errors = 0;
        cycle_count = 0;
        quiet_cycles = -100;
        in_taken = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cfg_ready_to = 24'hFFFFFF;
        cfg_token_to = 16'hFFFF;
        cfg_resp_polls = 8'd32;
        cfg_idle_retries = 8'd21;
        cfg_init_retries = 16'hFFFF;
        eng_phase = PH_IDLE;
        eng_op = OP_NONE;
        card_type = sdspi_pkg::KIND_NONE;
        kind_wip = sdspi_pkg::KIND_NONE;
        result_code = sdspi_pkg::ST_OK;
        clk_fast = 1'b0;
        address = '0;
        blocks_left = '0;
        byte_index = '0;
        poll_count = '0;
        attempt_count = '0;
        cur_cmd = '0;
        last_r1 = 8'hFF;
        trailer = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Requests before any card is known, and ignored requests.
        queue_request(random_req(sdspi_pkg::CMD_READ));
        queue_request(random_req(sdspi_pkg::CMD_WRITE));
        queue_request(random_req(sdspi_pkg::CMD_REG));
        queue_request(random_req(sdspi_pkg::CMD_BYTE));
        queue_request(random_req(3'd7));
        queue_request(random_req(3'd5));

        issued = 0;
        op_count = 0;
        sel = 0;
        while (issued < ITEM_TARGET) begin
            if (eng_phase == PH_IDLE) begin
                if (op_count % 5 == 0) begin
                    load_settings(sel);
                    sel++;
                end
                op_count++;
                if ($urandom_range(99) < 5) begin
                    it = random_req(3'($urandom_range(4, 7)));
                end else begin
                    if (card_type == sdspi_pkg::KIND_NONE && $urandom_range(99) < 85) begin
                        it = random_req(sdspi_pkg::CMD_INIT);
                    end else if ($urandom_range(99) < 10) begin
                        it = random_req(sdspi_pkg::CMD_INIT);
                    end else begin
                        it = random_req(3'($urandom_range(1, 3)));
                        if (it.cmd != sdspi_pkg::CMD_REG) begin
                            it.block_count = ($urandom_range(99) < 75) ? 8'd1
                                           : 8'($urandom_range(0, 3));
                        end
                    end
                    issued++;
                end
            end else if ($urandom_range(99) < 3) begin
                it = random_req(($urandom_range(1) != 0) ? 3'($urandom_range(0, 3))
                                                         : 3'($urandom_range(5, 7)));
            end else begin
                it = random_req(sdspi_pkg::CMD_BYTE);
                it.rx_byte = card_answer();
                issued++;
            end
            queue_request(it);
        end

        wait (pending_q.size() == 0 && expected_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* filelist.f */
design/sdspi_pkg.sv
design/sdspi_cfg_regs.sv
design/sdspi_engine.sv
design/sd_spi_host_engine_core.sv
dv/sd_spi_host_engine_core_tb.sv
